### hdl/ppt_pkg.sv
// Shared constants and types for the perspective point transform.
package ppt_pkg;

  localparam int NumRegs   = 8;
  localparam int RegWidth  = 64;
  localparam int IdxWidth  = 3;
  localparam int CoordW    = 32;
  localparam int CoordData = 3 * CoordW;

  typedef logic [RegWidth-1:0] reg_word_t;

  localparam reg_word_t RegReset [NumRegs] = '{
    64'd281474976710656, 64'd0, 64'd65536, 64'd0,
    64'd0, 64'd281474976710656, 64'd0, 64'd65536
  };

  typedef struct packed {
    logic overflow;
    logic w_zero;
  } out_flags_t;

endpackage

### hdl/perspective_point_transform.sv
// Top level: 4x4 point transform with pipelined perspective divide.
//
//  channel   | direction | handshake              | payload
//  s_axis    | in        | tvalid/tready          | tdata: x_in, y_in, z_in
//  m_axis    | out       | tvalid/tready          | tdata: x_out, y_out, z_out; tuser flags
//  cfg       | in        | cfg_we_i               | cfg_idx_i, cfg_data_i
//
// One transaction per cycle in each direction while the output is not stalled; the
// 32 one-bit restoring-divider stages follow the multiply and sum stages.
// Reset is asynchronous, active low; it clears valid bits and loads ppt_pkg::RegReset.
// A stall at the output freezes every stage at once; nothing is lost or repeated.
module perspective_point_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [ppt_pkg::CoordData-1:0] s_axis_tdata,  // x_in, y_in, z_in
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [ppt_pkg::CoordData-1:0] m_axis_tdata,  // x_out, y_out, z_out
  output logic [1:0]                    m_axis_tuser,  // w_zero, overflow
  input  logic                          cfg_we_i,
  input  logic [ppt_pkg::IdxWidth-1:0]  cfg_idx_i,
  input  logic [ppt_pkg::RegWidth-1:0]  cfg_data_i
);

  localparam int SW    = 66 - FRAC_BITS;
  localparam int NSH   = 32 - FRAC_BITS;
  localparam int QBITS = ppt_pkg::CoordW;

  typedef struct packed {
    logic [SW-1:0]    rem;
    logic [QBITS-1:0] low;
    logic [QBITS-1:0] quo;
    logic             neg;
    logic             sat;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   lane;
    logic [SW-1:0] den;
    logic          wz;
  } div_t;

  ppt_pkg::reg_word_t regs_q [ppt_pkg::NumRegs];

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppt_pkg::NumRegs; i++) regs_q[i] <= ppt_pkg::RegReset[i];
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic signed [31:0] coef [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        coef[r][c] = (c % 2 == 0) ? regs_q[r*2 + c/2][63:32] : regs_q[r*2 + c/2][31:0];
      end
    end
  end

  // valid chain: input, product, sum, prep, 32 divide steps, output
  logic in_vld_q, prod_vld_q, sum_vld_q;
  logic [QBITS:0] div_vld_q;
  logic out_vld_q;

  logic signed [31:0] pt_q [3];
  logic signed [63:0] prod_q [3][4];
  logic signed [SW-1:0] sum_q [4];
  div_t div_q [QBITS+1];
  div_t div_d [QBITS];

  logic [ppt_pkg::CoordData-1:0] odata_q;
  ppt_pkg::out_flags_t oflags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      sum_vld_q  <= 1'b0;
      div_vld_q  <= '0;
      out_vld_q  <= 1'b0;
    end else if (en) begin
      in_vld_q   <= s_axis_tvalid;
      prod_vld_q <= in_vld_q;
      sum_vld_q  <= prod_vld_q;
      div_vld_q  <= {div_vld_q[QBITS-1:0], sum_vld_q};
      out_vld_q  <= div_vld_q[QBITS];
    end
  end

  logic signed [SW-1:0] sum_d [4];
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum_d[c] = {{(SW-32){coef[3][c][31]}}, coef[3][c]};
      for (int r = 0; r < 3; r++) begin
        sum_d[c] = sum_d[c] + {{2{prod_q[r][c][63]}}, prod_q[r][c][63:FRAC_BITS]};
      end
    end
  end

  div_t prep_d;
  always_comb begin
    logic [SW-1:0] nm;
    logic [SW-1:0] dm;
    dm = sum_q[3][SW-1] ? SW'(-sum_q[3]) : SW'(sum_q[3]);
    prep_d.den = dm;
    prep_d.wz  = (sum_q[3] == '0);
    for (int l = 0; l < 3; l++) begin
      nm = sum_q[l][SW-1] ? SW'(-sum_q[l]) : SW'(sum_q[l]);
      prep_d.lane[l].rem = SW'(nm >> NSH);
      prep_d.lane[l].low = {nm[NSH-1:0], {FRAC_BITS{1'b0}}};
      prep_d.lane[l].quo = '0;
      prep_d.lane[l].neg = sum_q[l][SW-1] ^ sum_q[3][SW-1];
      prep_d.lane[l].sat = (SW'(nm >> NSH) >= dm);
    end
  end

  for (genvar k = 0; k < QBITS; k++) begin : g_div
    always_comb begin
      logic [SW:0] trial;
      logic        take;
      div_d[k] = div_q[k];
      for (int l = 0; l < 3; l++) begin
        trial = {div_q[k].lane[l].rem, div_q[k].lane[l].low[QBITS-1]};
        take  = (trial >= {1'b0, div_q[k].den});
        div_d[k].lane[l].rem = take ? SW'(trial - {1'b0, div_q[k].den}) : SW'(trial);
        div_d[k].lane[l].low = {div_q[k].lane[l].low[QBITS-2:0], 1'b0};
        div_d[k].lane[l].quo = {div_q[k].lane[l].quo[QBITS-2:0], take};
      end
    end
  end

  logic [ppt_pkg::CoordData-1:0] odata_d;
  ppt_pkg::out_flags_t oflags_d;
  always_comb begin
    logic [QBITS:0] mag;
    logic           ovf;
    ovf = 1'b0;
    for (int l = 0; l < 3; l++) begin
      mag = div_q[QBITS].lane[l].sat ? {1'b1, {QBITS{1'b0}}}
                                     : {1'b0, div_q[QBITS].lane[l].quo};
      if (div_q[QBITS].lane[l].neg) begin
        if (mag > 33'h0_8000_0000) begin
          ovf = 1'b1;
          odata_d[l*32 +: 32] = 32'h8000_0000;
        end else begin
          odata_d[l*32 +: 32] = 32'(-mag);
        end
      end else if (mag > 33'h0_7FFF_FFFF) begin
        ovf = 1'b1;
        odata_d[l*32 +: 32] = 32'h7FFF_FFFF;
      end else begin
        odata_d[l*32 +: 32] = mag[31:0];
      end
    end
    oflags_d.w_zero   = div_q[QBITS].wz;
    oflags_d.overflow = div_q[QBITS].wz ? 1'b0 : ovf;
    if (div_q[QBITS].wz) odata_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) pt_q[i] <= s_axis_tdata[i*32 +: 32];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) prod_q[r][c] <= pt_q[r] * coef[r][c];
      end
      for (int c = 0; c < 4; c++) sum_q[c] <= sum_d[c];
      div_q[0] <= prep_d;
      for (int k = 0; k < QBITS; k++) div_q[k+1] <= div_d[k];
      odata_q  <= odata_d;
      oflags_q <= oflags_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = oflags_q;

endmodule

### hdl/ppt_checker.sv
// Port-level checker for the perspective point transform, with its bind.
module ppt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ppt_pkg::CoordData-1:0] m_axis_tdata,
  input logic [1:0]                    m_axis_tuser
);

  a_wzero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
    else $error("w_zero result not cleared");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not track output stall");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output transaction changed");

endmodule

bind perspective_point_transform ppt_checker u_ppt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

### bench/perspective_point_transform_tb.sv
// Testbench for the perspective point transform: scoreboard-checked random and directed points.
`timescale 1ns / 1ps

module perspective_point_transform_tb;

  typedef struct packed {
    logic overflow;
    logic w_zero;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } point_result_t;

  class point_scoreboard;
    ppt_pkg::reg_word_t matrix [ppt_pkg::NumRegs];
    point_result_t pending [$];
    int errors;

    function new();
      for (int i = 0; i < ppt_pkg::NumRegs; i++) matrix[i] = ppt_pkg::RegReset[i];
      errors = 0;
    endfunction

    function void write_reg(int idx, ppt_pkg::reg_word_t val);
      if (idx < ppt_pkg::NumRegs) matrix[idx] = val;
    endfunction

    function logic signed [63:0] coefficient(int r, int c);
      ppt_pkg::reg_word_t w;
      w = matrix[(r * 2 + c / 2) & 7];
      return (c % 2) ? 64'(signed'(w[31:0])) : 64'(signed'(w[63:32]));
    endfunction

    function logic signed [31:0] divide(logic signed [63:0] num, logic signed [63:0] den,
                                        inout logic ovf);
      logic neg;
      logic [63:0] n, d, q, r, mag;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = n / d;
      r = n % d;
      if (q >= (64'd1 << 16)) mag = 64'd1 << 32;
      else mag = (q << 16) | ((r << 16) / d);
      if (neg) begin
        if (mag > 64'h80000000) begin
          ovf = 1'b1;
          return 32'h80000000;
        end
        return -mag[31:0];
      end
      if (mag > 64'h7FFFFFFF) begin
        ovf = 1'b1;
        return 32'h7FFFFFFF;
      end
      return mag[31:0];
    endfunction

    function void note_point(logic [ppt_pkg::CoordData-1:0] data);
      logic signed [63:0] p [3];
      logic signed [63:0] s [4];
      logic signed [127:0] prod;
      point_result_t res;
      logic ovf;
      for (int i = 0; i < 3; i++) p[i] = 64'(signed'(data[32*i +: 32]));
      for (int c = 0; c < 4; c++) begin
        s[c] = coefficient(3, c);
        for (int r = 0; r < 3; r++) begin
          prod = 128'(p[r]) * 128'(coefficient(r, c));
          s[c] += 64'(prod >>> 16);
        end
      end
      res = '0;
      ovf = 1'b0;
      if (s[3] == 0) res.w_zero = 1'b1;
      else begin
        res.x = divide(s[0], s[3], ovf);
        res.y = divide(s[1], s[3], ovf);
        res.z = divide(s[2], s[3], ovf);
        res.overflow = ovf;
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [ppt_pkg::CoordData-1:0] data, logic [1:0] user);
      point_result_t got, exp;
      got = {user, data};
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.x !== exp.x) $display("%0t: x expected %h actual %h", $time, exp.x, got.x);
      if (got.y !== exp.y) $display("%0t: y expected %h actual %h", $time, exp.y, got.y);
      if (got.z !== exp.z) $display("%0t: z expected %h actual %h", $time, exp.z, got.z);
      if (got.w_zero !== exp.w_zero)
        $display("%0t: w_zero expected %b actual %b", $time, exp.w_zero, got.w_zero);
      if (got.overflow !== exp.overflow)
        $display("%0t: overflow expected %b actual %b", $time, exp.overflow, got.overflow);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [ppt_pkg::CoordData-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ppt_pkg::CoordData-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [ppt_pkg::IdxWidth-1:0] cfg_idx_i = '0;
  ppt_pkg::reg_word_t cfg_data_i = '0;

  int send_idle_pct, recv_stall_pct;
  int cycles;
  point_scoreboard board;

  localparam int Latency = 37;
  localparam int CycleLimit = 400000;

  perspective_point_transform DUT (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("perspective_point_transform_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom;
      default: return 32'($signed($urandom_range(2 * 655360)) - 655360);
    endcase
  endfunction

  function automatic logic [31:0] pick_coef();
    case ($urandom_range(9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom;
      default: return 32'($signed($urandom_range(4 * 65536)) - 2 * 65536);
    endcase
  endfunction

  task automatic send_point(logic [ppt_pkg::CoordData-1:0] data);
    cfg_we_i <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_point(data);
  endtask

  task automatic write_reg(int idx, ppt_pkg::reg_word_t val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx[ppt_pkg::IdxWidth-1:0];
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic load_matrix(int kind);
    ppt_pkg::reg_word_t val;
    for (int i = 0; i < ppt_pkg::NumRegs; i++) begin
      case (kind)
        0: val = ppt_pkg::RegReset[i];
        1: val = '1;
        2: val = {32'h80000000, 32'h7FFFFFFF};
        default: val = {pick_coef(), pick_coef()};
      endcase
      if (kind > 2 && i == 7 && $urandom_range(3) == 0) val[31:0] = 32'h0;
      write_reg(i, val);
    end
  endtask

  initial begin
    logic [31:0] c [3];
    board = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point('0);
    send_point({32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    send_point({32'h80000000, 32'h80000000, 32'h80000000});
    send_point({32'h00010000, 32'hFFFF0000, 32'h00008000});
    send_point({32'hFFFFFFFF, 32'h00000001, 32'h55555555});
    drain();
    load_matrix(1);
    send_point('0);
    send_point({32'h7FFFFFFF, 32'h80000000, 32'h00010000});
    drain();
    load_matrix(2);
    send_point({32'h00010000, 32'h00010000, 32'h00010000});
    send_point({32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF});
    drain();
    // W column all zero: every point hits the zero divisor case
    write_reg(1, '0);
    write_reg(3, '0);
    write_reg(5, '0);
    write_reg(7, '0);
    send_point({32'h1, 32'h2, 32'h3});
    drain();
    // reset matrix with a tiny bottom-right coefficient
    load_matrix(0);
    write_reg(7, 64'h1);
    send_point({32'h00010000, 32'hFFFF0000, 32'h00100000});
    send_point('0);
    drain();

    for (int phase = 0; phase < 24; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      load_matrix(phase == 0 ? 0 : 3);
      for (int n = 0; n < 60; n++) begin
        for (int k = 0; k < 3; k++) c[k] = pick_coord();
        send_point({c[2], c[1], c[0]});
      end
      drain();
    end

    if (board.errors == 0) $display("perspective_point_transform_tb: PASS");
    else $display("perspective_point_transform_tb: FAIL");
    $finish;
  end
endmodule

### sim.f
hdl/ppt_pkg.sv
hdl/perspective_point_transform.sv
hdl/ppt_checker.sv
bench/perspective_point_transform_tb.sv
